// ===== rtl/plal_pkg.sv =====
// ---------------------------------------------------------------------------
// Polyline point at arc length: shared types and constants
// Sequencer states, result status codes and datapath widths of the
// bit-serial arithmetic.
// ---------------------------------------------------------------------------
package plal_pkg;

   // Width of a coordinate difference and of its magnitude.
   localparam int MAG_W  = 33;
   // Width of a product of two magnitudes, and of a sum of two squares.
   localparam int PROD_W = 2 * MAG_W;
   // Square root remainder width and division remainder width.
   localparam int SQREM_W = MAG_W + 3;
   localparam int DVREM_W = MAG_W + 1;
   // Quotient width kept by the divider.
   localparam int QUO_W  = MAG_W + 1;
   // Step counter width, enough to count PROD_W steps.
   localparam int STEP_W = $clog2(PROD_W + 1);

   localparam logic [1:0] STATUS_SEGMENT = 2'd0;
   localparam logic [1:0] STATUS_SINGLE  = 2'd1;
   localparam logic [1:0] STATUS_NONE    = 2'd2;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b00000000001,
      ST_FIRST_W = 11'b00000000010,
      ST_FIRST   = 11'b00000000100,
      ST_FETCH   = 11'b00000001000,
      ST_SEG     = 11'b00000010000,
      ST_SQ      = 11'b00000100000,
      ST_SQRT    = 11'b00001000000,
      ST_CMP     = 11'b00010000000,
      ST_MUL     = 11'b00100000000,
      ST_DIV     = 11'b01000000000,
      ST_DONE    = 11'b10000000000
   } state_type;

endpackage

// ===== rtl/polyline_point_at_arc_length.sv =====
// ---------------------------------------------------------------------------
// Polyline point at arc length
// Stores polyline vertices and returns the point at a given arc length,
// working through lengths, square roots and divisions one bit per cycle.
// ---------------------------------------------------------------------------
// Usage. One input stream (req_) carries load and query words; one output
// stream (rsp_) carries one result word per query and nothing for a load.
// A load is taken while idle and appends a vertex to the on-chip store
// (restart empties it first; loads to a full store are dropped).
// A query walks the segments in order. Each segment costs a fetch, two
// bit-serial squares, a bit-serial square root and a compare; the segment
// found then costs a bit-serial multiply and a restoring divide per axis.
// An empty or single-vertex store answers without walking any segment.
// One word is worked on at a time.
// Reset empties the store and the sequencer; store contents need none.
// The result sits in an output register: while the receiver stalls, loads
// are still taken, and a new query runs up to its end and then waits.
// ---------------------------------------------------------------------------
module polyline_point_at_arc_length #(
   parameter int MAX_VERTICES = 64,
   parameter int FRAC_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] vertex_x, [63:32] vertex_y, [95:64] query_distance
   input  logic [95:0] req_tdata,
   // [0] action, [1] restart
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] pos_x, [63:32] pos_y
   output logic [63:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser
);

   localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int SUM_W = plal_pkg::MAG_W + 1 + AW;
   localparam int MW    = plal_pkg::MAG_W;
   localparam int PW    = plal_pkg::PROD_W;
   localparam int SW    = plal_pkg::STEP_W;
   // s*1000 < 2^FRAC_BITS holds exactly when s <= floor((2^FRAC_BITS - 1) / 1000).
   localparam logic signed [31:0] SINGLE_LIMIT = 32'((2 ** FRAC_BITS - 1) / 1000);

   function automatic logic [MW-1:0] abs_mag(input logic signed [MW-1:0] v);
      abs_mag = v[MW-1] ? MW'(-v) : MW'(v);
   endfunction

   function automatic logic [31:0] place(input logic [31:0] base,
                                         input logic [plal_pkg::QUO_W-1:0] q,
                                         input logic neg);
      logic [34:0] off;
      logic [34:0] tot;
      off = neg ? (35'd0 - {1'b0, q}) : {1'b0, q};
      tot = {{3{base[31]}}, base} + off;
      if (tot[34:31] == 4'b0000 || tot[34:31] == 4'b1111) begin
         place = tot[31:0];
      end else begin
         place = tot[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
   endfunction

   plal_pkg::state_type state_ff, state_in;

   logic [31:0] mem_x [MAX_VERTICES];
   logic [31:0] mem_y [MAX_VERTICES];
   logic [31:0] rdx_ff, rdy_ff;

   logic [CW-1:0]   cnt_ff, cnt_in, idx_ff, idx_in;
   logic [31:0]     s_ff, s_in, x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [MW-1:0]   dx_ff, dx_in, dy_ff, dy_in, num_ff, num_in, mc_ff, mc_in;
   logic [MW-1:0]   root_ff, root_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [PW-1:0]   prod_ff, prod_in, sq_ff, sq_in, rad_ff, rad_in;
   logic [plal_pkg::SQREM_W-1:0] rem_ff, rem_in;
   logic [plal_pkg::QUO_W-1:0]   q_ff, q_in;
   logic [SW-1:0]   step_ff, step_in;
   logic            axis_ff, axis_in;
   logic [31:0]     resx_ff, resx_in, resy_ff, resy_in;
   logic [1:0]      ress_ff, ress_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [63:0]     rsp_data_ff, rsp_data_in;
   logic [1:0]      rsp_user_ff, rsp_user_in;

   logic            load_we;
   logic [AW-1:0]   load_addr;

   // Datapath pieces used by the bit-serial steps.
   logic [MW:0]     mul_add;
   logic [plal_pkg::SQREM_W-1:0] sq_r4, sq_trial;
   logic [plal_pkg::DVREM_W-1:0] dv_r2, dv_den;
   logic [SUM_W-1:0] next_sum;
   logic            hit;
   logic            neg_cur;

   assign mul_add  = {1'b0, prod_ff[PW-1:MW]} + {1'b0, mc_ff};
   assign sq_r4    = {rem_ff[plal_pkg::SQREM_W-3:0], rad_ff[PW-1:PW-2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign dv_r2    = {rem_ff[plal_pkg::DVREM_W-2:0], rad_ff[PW-1]};
   assign dv_den   = {1'b0, root_ff};
   assign next_sum = sum_ff + SUM_W'(root_ff);
   assign hit      = $signed({{(SUM_W + 1 - 32){s_ff[31]}}, s_ff}) < $signed({1'b0, next_sum});
   assign neg_cur  = (axis_ff ? dy_ff[MW-1] : dx_ff[MW-1]) ^ num_ff[MW-1];

   assign req_tready = (state_ff == plal_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      s_in      = s_ff;
      x0_in     = x0_ff;
      y0_in     = y0_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      num_in    = num_ff;
      mc_in     = mc_ff;
      root_in   = root_ff;
      sum_in    = sum_ff;
      prod_in   = prod_ff;
      sq_in     = sq_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      step_in   = step_ff;
      axis_in   = axis_ff;
      resx_in   = resx_ff;
      resy_in   = resy_ff;
      ress_in   = ress_ff;
      load_we   = 1'b0;
      load_addr = AW'(0);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      unique case (state_ff)
         plal_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (!req_tuser[0]) begin
                  if (req_tuser[1] || cnt_ff < CW'(MAX_VERTICES)) begin
                     load_we   = 1'b1;
                     load_addr = req_tuser[1] ? AW'(0) : cnt_ff[AW-1:0];
                     cnt_in    = req_tuser[1] ? CW'(1) : cnt_ff + CW'(1);
                  end
               end else begin
                  s_in    = req_tdata[95:64];
                  idx_in  = CW'(0);
                  sum_in  = '0;
                  resx_in = '0;
                  resy_in = '0;
                  ress_in = plal_pkg::STATUS_NONE;
                  state_in = (cnt_ff == CW'(0)) ? plal_pkg::ST_DONE : plal_pkg::ST_FIRST_W;
               end
            end
         end
         plal_pkg::ST_FIRST_W: state_in = plal_pkg::ST_FIRST;
         plal_pkg::ST_FIRST: begin
            x0_in = rdx_ff;
            y0_in = rdy_ff;
            if (cnt_ff == CW'(1)) begin
               if ($signed(s_ff) <= SINGLE_LIMIT) begin
                  resx_in = rdx_ff;
                  resy_in = rdy_ff;
                  ress_in = plal_pkg::STATUS_SINGLE;
               end
               state_in = plal_pkg::ST_DONE;
            end else begin
               idx_in   = CW'(1);
               state_in = plal_pkg::ST_FETCH;
            end
         end
         plal_pkg::ST_FETCH: state_in = plal_pkg::ST_SEG;
         plal_pkg::ST_SEG: begin
            x1_in   = rdx_ff;
            y1_in   = rdy_ff;
            dx_in   = MW'({rdx_ff[31], rdx_ff} - {x0_ff[31], x0_ff});
            dy_in   = MW'({rdy_ff[31], rdy_ff} - {y0_ff[31], y0_ff});
            mc_in   = abs_mag(dx_in);
            prod_in = {{MW{1'b0}}, abs_mag(dx_in)};
            step_in = '0;
            axis_in = 1'b0;
            state_in = plal_pkg::ST_SQ;
         end
         plal_pkg::ST_SQ, plal_pkg::ST_MUL: begin
            // Shift-and-add: one multiplier bit per cycle, product shifts right.
            prod_in = prod_ff[0] ? {mul_add, prod_ff[MW-1:1]} : {1'b0, prod_ff[PW-1:1]};
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(MW - 1)) begin
               step_in = '0;
               if (state_ff == plal_pkg::ST_MUL) begin
                  rad_in   = prod_in;
                  rem_in   = '0;
                  q_in     = '0;
                  state_in = plal_pkg::ST_DIV;
               end else if (!axis_ff) begin
                  sq_in   = prod_in;
                  mc_in   = abs_mag(dy_ff);
                  prod_in = {{MW{1'b0}}, abs_mag(dy_ff)};
                  axis_in = 1'b1;
               end else begin
                  rad_in   = sq_ff + prod_in;
                  rem_in   = '0;
                  root_in  = '0;
                  state_in = plal_pkg::ST_SQRT;
               end
            end
         end
         plal_pkg::ST_SQRT: begin
            // Digit-by-digit root: one pair of radicand bits per cycle.
            if (sq_r4 >= sq_trial) begin
               rem_in  = sq_r4 - sq_trial;
               root_in = {root_ff[MW-2:0], 1'b1};
            end else begin
               rem_in  = sq_r4;
               root_in = {root_ff[MW-2:0], 1'b0};
            end
            rad_in  = {rad_ff[PW-3:0], 2'b00};
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(MW - 1)) begin
               step_in  = '0;
               state_in = plal_pkg::ST_CMP;
            end
         end
         plal_pkg::ST_CMP: begin
            if (hit) begin
               ress_in = plal_pkg::STATUS_SEGMENT;
               if (root_ff == '0) begin
                  resx_in  = x0_ff;
                  resy_in  = y0_ff;
                  state_in = plal_pkg::ST_DONE;
               end else begin
                  // Before a hit past the first segment s >= sum, so sum fits 32 bits.
                  num_in   = {s_ff[31], s_ff} - {1'b0, sum_ff[31:0]};
                  mc_in    = abs_mag(dx_ff);
                  prod_in  = {{MW{1'b0}}, abs_mag(num_in)};
                  axis_in  = 1'b0;
                  state_in = plal_pkg::ST_MUL;
               end
            end else begin
               sum_in = next_sum;
               idx_in = idx_ff + CW'(1);
               if (idx_in == cnt_ff) begin
                  state_in = plal_pkg::ST_DONE;
               end else begin
                  x0_in    = x1_ff;
                  y0_in    = y1_ff;
                  state_in = plal_pkg::ST_FETCH;
               end
            end
         end
         plal_pkg::ST_DIV: begin
            // Restoring division, one dividend bit per cycle.
            if (dv_r2 >= dv_den) begin
               rem_in = plal_pkg::SQREM_W'(dv_r2 - dv_den);
               q_in   = {q_ff[plal_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in = plal_pkg::SQREM_W'(dv_r2);
               q_in   = {q_ff[plal_pkg::QUO_W-2:0], 1'b0};
            end
            rad_in  = {rad_ff[PW-2:0], 1'b0};
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(PW - 1)) begin
               step_in = '0;
               if (!axis_ff) begin
                  resx_in  = place(x0_ff, q_in, neg_cur);
                  mc_in    = abs_mag(dy_ff);
                  prod_in  = {{MW{1'b0}}, abs_mag(num_ff)};
                  axis_in  = 1'b1;
                  state_in = plal_pkg::ST_MUL;
               end else begin
                  resy_in  = place(y0_ff, q_in, neg_cur);
                  state_in = plal_pkg::ST_DONE;
               end
            end
         end
         plal_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {resy_ff, resx_ff};
               rsp_user_in  = ress_ff;
               state_in     = plal_pkg::ST_IDLE;
            end
         end
         default: state_in = plal_pkg::ST_IDLE;
      endcase
   end

   // Vertex store: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (load_we) begin
         mem_x[load_addr] <= req_tdata[31:0];
         mem_y[load_addr] <= req_tdata[63:32];
      end
      rdx_ff <= mem_x[idx_ff[AW-1:0]];
      rdy_ff <= mem_y[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plal_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      s_ff        <= s_in;
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      num_ff      <= num_in;
      mc_ff       <= mc_in;
      root_ff     <= root_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      sq_ff       <= sq_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      step_ff     <= step_in;
      axis_ff     <= axis_in;
      resx_ff     <= resx_in;
      resy_ff     <= resy_in;
      ress_ff     <= ress_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // The vertex count never passes the store's depth.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_VERTICES))
      else $error("vertex count exceeds store depth");

   // A segment is only ever taken between two stored vertices.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == plal_pkg::ST_SEG) |-> (idx_ff != CW'(0) && idx_ff < cnt_ff))
      else $error("segment index outside stored vertices");

   // Leaving the final state always presents a result word.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == plal_pkg::ST_DONE && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("finished query produced no result word");

   // The square root remainder stays within twice the partial root.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == plal_pkg::ST_SQRT) |-> (rem_ff <= {2'b00, root_ff, 1'b0}))
      else $error("square root remainder out of range");

endmodule

// ===== bench/plal_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Polyline point at arc length: stream checker
// Watches the load/query and result streams, keeps its own copy of the
// vertex store, predicts each query result and compares it field by field.
// ---------------------------------------------------------------------------
module plal_checker #(
   parameter int MAX_VERTICES = 64,
   parameter int FRAC_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [1:0]         status;
   } point_type;

   logic signed [31:0] px_store [MAX_VERTICES];
   logic signed [31:0] py_store [MAX_VERTICES];
   int                 n_vertices;
   point_type          expected_points [$];

   function automatic logic [31:0] clamp32(logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -66'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Integer square root, floor, of a value below 2^66.
   function automatic logic [33:0] root66(logic [65:0] v);
      logic [33:0] r;
      logic [67:0] t;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
         t = {34'd0, r | (34'd1 << b)};
         if (t * t <= {2'b00, v}) r = r | (34'd1 << b);
      end
      return r;
   endfunction

   // d * num / len with the magnitude truncated.
   function automatic logic signed [65:0] ratio_offset(logic signed [33:0] d,
         logic signed [65:0] num, logic [33:0] len);
      logic [127:0] p;
      logic [127:0] q;
      logic [33:0]  ad;
      logic [65:0]  an;
      ad = d < 0 ? -d : d;
      an = num < 0 ? -num : num;
      p  = {94'd0, ad} * {62'd0, an};
      q  = p / {94'd0, len};
      return ((d < 0) != (num < 0)) ? -$signed(q[65:0]) : $signed(q[65:0]);
   endfunction

   function automatic point_type locate_point(logic signed [31:0] s);
      point_type          r;
      logic signed [65:0] acc, nxt;
      logic signed [33:0] dx, dy;
      logic [65:0]        sq;
      logic [33:0]        len;
      logic signed [65:0] ox, oy;
      r = '{0, 0, plal_pkg::STATUS_NONE};
      if (n_vertices == 1) begin
         if ($signed(66'(s)) * 1000 < (66'sd1 <<< FRAC_BITS))
            r = '{px_store[0], py_store[0], plal_pkg::STATUS_SINGLE};
         return r;
      end
      acc = 0;
      for (int i = 1; i < n_vertices; i++) begin
         dx  = 34'(px_store[i]) - 34'(px_store[i-1]);
         dy  = 34'(py_store[i]) - 34'(py_store[i-1]);
         sq  = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
         len = root66(sq);
         nxt = acc + $signed({32'd0, len});
         if (66'(s) < nxt) begin
            ox = 0;
            oy = 0;
            if (len != 0) begin
               ox = ratio_offset(dx, 66'(s) - acc, len);
               oy = ratio_offset(dy, 66'(s) - acc, len);
            end
            r.pos_x  = clamp32(66'(px_store[i-1]) + ox);
            r.pos_y  = clamp32(66'(py_store[i-1]) + oy);
            r.status = plal_pkg::STATUS_SEGMENT;
            return r;
         end
         acc = nxt;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      point_type e, got;
      if (reset) begin
         n_vertices   <= 0;
         fail_count   <= 0;
         result_count <= 0;
         expected_points.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser};
            result_count <= result_count + 1;
            if (expected_points.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result word x=%h y=%h st=%0d",
                     got.pos_x, got.pos_y, got.status);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_points.pop_front();
               if (e != got) begin
                  if (fail_count < 10)
                     $display("mismatch: expected x=%h y=%h st=%0d, got x=%h y=%h st=%0d",
                        e.pos_x, e.pos_y, e.status, got.pos_x, got.pos_y, got.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // Prediction uses the store as it stands before this word's load.
         if (req_tvalid && req_tready) begin
            if (req_tuser[0]) begin
               expected_points.push_back(locate_point(req_tdata[95:64]));
            end else if (req_tuser[1]) begin
               px_store[0] <= req_tdata[31:0];
               py_store[0] <= req_tdata[63:32];
               n_vertices  <= 1;
            end else if (n_vertices < MAX_VERTICES) begin
               px_store[n_vertices] <= req_tdata[31:0];
               py_store[n_vertices] <= req_tdata[63:32];
               n_vertices <= n_vertices + 1;
            end
         end
      end
   end

   assign pending_count = expected_points.size();

endmodule

// ===== bench/tb_polyline_point_at_arc_length.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Polyline point at arc length: testbench top
// Drives load and query words with random gaps and result stalls; the
// checker predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_polyline_point_at_arc_length;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
   localparam int   CYCLE_LIMIT = 3_000_000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          fail_count, pending_count, result_count;
   int          cycle_count = 0;
   bit          no_gaps = 0;
   int          n_loads = 0, n_queries = 0;

   always #5 clock = ~clock;

   polyline_point_at_arc_length dut (.*);

   plal_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout");
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 32);

   // The valid line stays high between words sent back to back.
   task automatic send_word(logic act, logic rst, logic [31:0] x, logic [31:0] y,
         logic [31:0] s);
      while (!no_gaps && $urandom_range(99) < 32) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= {rst, act};
      req_tdata  <= {s, y, x};
      do @(posedge clock); while (!req_tready);
      if (act == ACT_QUERY) n_queries++; else n_loads++;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(200000)) - 100000);
      endcase
   endfunction

   initial begin
      int nv;
      int n;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Empty store, then a single vertex around the small-distance threshold.
      send_word(ACT_QUERY, 0, 0, 0, 0);
      send_word(ACT_LOAD, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_word(ACT_QUERY, 0, 0, 0, 32'd65);
      send_word(ACT_QUERY, 0, 0, 0, 32'd66);
      send_word(ACT_QUERY, 0, 0, 0, 32'h8000_0000);
      // Extreme segment: full-range coordinates, negative and large distances.
      send_word(ACT_LOAD, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_word(ACT_QUERY, 0, 0, 0, 32'h8000_0000);
      send_word(ACT_QUERY, 0, 0, 0, 32'h7FFF_FFFF);
      send_word(ACT_QUERY, 0, 0, 0, 32'h4000_0000);
      // Zero-length segment.
      send_word(ACT_LOAD, 1, 32'h10000, 32'h20000, 0);
      send_word(ACT_LOAD, 0, 32'h10000, 32'h20000, 0);
      send_word(ACT_QUERY, 0, 0, 0, 32'hFFFF_FFFF);
      send_word(ACT_QUERY, 0, 0, 0, 0);
      // Fill past capacity with two extra loads, then query the full store.
      for (int i = 0; i < 66; i++)
         send_word(ACT_LOAD, i == 0, 32'(i) <<< 16, 32'(i % 2) <<< 16, 0);
      send_word(ACT_QUERY, 0, 0, 0, 32'h3F_0000);
      send_word(ACT_QUERY, 0, 0, 0, 32'h60_0000);
      // Random: mostly fresh short polylines, then queries at mixed distances.
      while (n_loads + n_queries < 320) begin
         no_gaps = (n_queries > 40 && n_queries < 60);
         nv = $urandom_range(9) == 0 ? $urandom_range(64, 40) : $urandom_range(6);
         for (int i = 0; i < nv; i++)
            send_word(ACT_LOAD, i == 0 || $urandom_range(30) == 0, rand_coord(),
               rand_coord(), $urandom());
         n = $urandom_range(4, 1);
         for (int i = 0; i < n; i++)
            case ($urandom_range(5))
               0: send_word(ACT_QUERY, 1'($urandom()), $urandom(), $urandom(), $urandom());
               1: send_word(ACT_QUERY, 0, 0, 0, -$urandom_range(300000));
               default: send_word(ACT_QUERY, 0, 0, 0, $urandom_range(1) ?
                  $urandom_range(500000) : ($urandom() >> $urandom_range(8)));
            endcase
      end
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d loads and %0d queries, %0d result words checked",
         n_loads, n_queries, result_count);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
